FILE: hw/rtl/sha1md_pkg.sv
// shared types, constants and helpers for the sha-1 message digest block
package sha1md_pkg;

    localparam int BlockBits = 512;
    localparam int WordBits  = 32;
    localparam int ChainLen  = 5;
    localparam int CountBits = 61;
    localparam int LenBits   = 64;
    localparam int FillBits  = 6;
    localparam int RndBits   = 7;

    localparam logic [FillBits-1:0] FILL_LAST    = 6'd63;
    localparam logic [FillBits-1:0] FILL_PAD_END = 6'd55;
    localparam logic [RndBits-1:0]  RND_LAST     = 7'd79;
    localparam logic [RndBits-1:0]  RND_PH1      = 7'd20;
    localparam logic [RndBits-1:0]  RND_PH2      = 7'd40;
    localparam logic [RndBits-1:0]  RND_PH3      = 7'd60;
    localparam logic [7:0]          PAD_BYTE     = 8'h80;
    localparam logic [2:0]          OUT_WORDS    = 3'd5;

    localparam logic [WordBits-1:0] H_INIT [ChainLen] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WordBits-1:0] K_CONST [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_FINAL
    } state_t;

    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_FINAL
    } ret_t;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } sel_t;

    typedef enum logic [1:0] {
        PH_CHOOSE,
        PH_PARITY1,
        PH_MAJORITY,
        PH_PARITY2
    } phase_t;

    typedef struct packed {
        logic   shift_en;
        sel_t   shift_sel;
        logic   count_en;
        logic   round_en;
        logic   round_first;
        phase_t phase;
        logic   add_en;
        logic   final_load;
    } cmd_t;

    typedef struct packed {
        logic [FillBits-1:0] fill;
        logic                out_busy;
    } status_t;

    function automatic logic [WordBits-1:0] rotl(input logic [WordBits-1:0] x,
                                                 input int n);
        rotl = (x << n) | (x >> (WordBits - n));
    endfunction

endpackage

FILE: hw/rtl/sha1md_ctrl.sv
// controller state machine: byte intake, padding, length, rounds and digest hand-off
module sha1md_ctrl
    import sha1md_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    byte_valid,
    input  logic    msg_end,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t              state_reg, state_next;
    ret_t                ret_reg, ret_next;
    logic                first_reg, first_next;
    logic [RndBits-1:0]  rnd_reg, rnd_next;
    logic                accept;

    assign accept = in_valid && in_ready;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= RET_IDLE;
            first_reg <= 1'b0;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            first_reg <= first_next;
            rnd_reg   <= rnd_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        first_next = first_reg;
        rnd_next   = rnd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    first_next = 1'b1;
                    if (byte_valid && st.fill == FILL_LAST)
                    begin
                        state_next = ST_ROUND;
                        ret_next   = msg_end ? RET_PAD : RET_IDLE;
                        rnd_next   = '0;
                    end
                    else if (msg_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                first_next = 1'b0;
                if (st.fill == FILL_LAST)
                begin
                    state_next = ST_ROUND;
                    ret_next   = RET_PAD;
                    rnd_next   = '0;
                end
                else if (st.fill == FILL_PAD_END)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (st.fill == FILL_LAST)
                begin
                    state_next = ST_ROUND;
                    ret_next   = RET_FINAL;
                    rnd_next   = '0;
                end
            end
            ST_ROUND:
            begin
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == RND_LAST)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                case (ret_reg)
                    RET_FINAL: state_next = ST_FINAL;
                    RET_PAD:   state_next = ST_PAD;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_FINAL:
            begin
                if (!st.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        if (rnd_reg < RND_PH1)
            cmd.phase = PH_CHOOSE;
        else if (rnd_reg < RND_PH2)
            cmd.phase = PH_PARITY1;
        else if (rnd_reg < RND_PH3)
            cmd.phase = PH_MAJORITY;
        else
            cmd.phase = PH_PARITY2;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.shift_en  = accept && byte_valid;
                cmd.count_en  = accept && byte_valid;
                cmd.shift_sel = SEL_DATA;
            end
            ST_PAD:
            begin
                cmd.shift_en  = 1'b1;
                cmd.shift_sel = first_reg ? SEL_PAD : SEL_ZERO;
            end
            ST_LEN:
            begin
                cmd.shift_en  = 1'b1;
                cmd.shift_sel = SEL_LEN;
            end
            ST_ROUND:
            begin
                cmd.round_en    = 1'b1;
                cmd.round_first = (rnd_reg == '0);
            end
            ST_ADD:
            begin
                cmd.add_en = 1'b1;
            end
            ST_FINAL:
            begin
                cmd.final_load = !st.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/sha1md_dp.sv
// datapath: block shift register, message schedule, round unit, chain and digest output
module sha1md_dp
    import sha1md_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  cmd_t                cmd,
    output status_t             st,
    output logic [WordBits-1:0] digest_word,
    output logic                word_last,
    output logic                out_valid,
    input  logic                out_ready
);

    logic [BlockBits-1:0] blk_reg, blk_next;
    logic [FillBits-1:0]  fill_reg;
    logic [CountBits-1:0] count_reg;
    logic [WordBits-1:0]  chain_reg [ChainLen];
    logic [WordBits-1:0]  work_reg [ChainLen];
    logic [WordBits-1:0]  dig_reg [ChainLen];
    logic [2:0]           left_reg;

    logic [7:0]           shift_byte;
    logic [LenBits-1:0]   len_shifted;
    logic [WordBits-1:0]  wa, wb, wc, wd, we;
    logic [WordBits-1:0]  f_val, t_val, w_new;
    logic                 out_take;

    assign st.fill     = fill_reg;
    assign st.out_busy = (left_reg != '0);
    assign out_valid   = st.out_busy;
    assign digest_word = dig_reg[0];
    assign word_last   = (left_reg == 3'd1);
    assign out_take    = out_valid && out_ready;

    // byte source: message data, pad marker, zero or length byte msb first
    assign len_shifted = {count_reg, 3'b000} << {fill_reg[2:0], 3'b000};
    always_comb
    begin
        case (cmd.shift_sel)
            SEL_DATA: shift_byte = data_byte;
            SEL_PAD:  shift_byte = PAD_BYTE;
            SEL_LEN:  shift_byte = len_shifted[LenBits-1 -: 8];
            default:  shift_byte = 8'h00;
        endcase
    end

    // round working values, taken from the chain on the first round
    always_comb
    begin
        if (cmd.round_first)
        begin
            wa = chain_reg[0];
            wb = chain_reg[1];
            wc = chain_reg[2];
            wd = chain_reg[3];
            we = chain_reg[4];
        end
        else
        begin
            wa = work_reg[0];
            wb = work_reg[1];
            wc = work_reg[2];
            wd = work_reg[3];
            we = work_reg[4];
        end
    end

    // round function and message schedule word
    always_comb
    begin
        case (cmd.phase)
            PH_CHOOSE:   f_val = (wb & wc) | (~wb & wd);
            PH_MAJORITY: f_val = (wb & wc) | (wb & wd) | (wc & wd);
            default:     f_val = wb ^ wc ^ wd;
        endcase
        t_val = rotl(wa, 5) + f_val + we + K_CONST[cmd.phase] + blk_reg[511 -: 32];
        w_new = rotl(blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416]
                     ^ blk_reg[511:480], 1);
    end

    // block buffer shifts bytes in, and whole words during rounds
    always_comb
    begin
        blk_next = blk_reg;
        if (cmd.shift_en)
            blk_next = {blk_reg[BlockBits-9:0], shift_byte};
        else if (cmd.round_en)
            blk_next = {blk_reg[BlockBits-WordBits-1:0], w_new};
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

    // round working registers
    always_ff @(posedge clk)
    begin
        if (cmd.round_en)
        begin
            work_reg[0] <= t_val;
            work_reg[1] <= wa;
            work_reg[2] <= rotl(wb, 30);
            work_reg[3] <= wc;
            work_reg[4] <= wd;
        end
    end

    // fill, length count and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
            for (int i = 0; i < ChainLen; i++)
                chain_reg[i] <= H_INIT[i];
        end
        else
        begin
            if (cmd.shift_en)
                fill_reg <= fill_reg + 1'b1;
            if (cmd.count_en)
                count_reg <= count_reg + 1'b1;
            if (cmd.add_en)
            begin
                for (int i = 0; i < ChainLen; i++)
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
            else if (cmd.final_load)
            begin
                count_reg <= '0;
                for (int i = 0; i < ChainLen; i++)
                    chain_reg[i] <= H_INIT[i];
            end
        end
    end

    // digest output beats: word count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= '0;
        else if (cmd.final_load)
            left_reg <= OUT_WORDS;
        else if (out_take)
            left_reg <= left_reg - 1'b1;
    end

    // digest output beats: word shift line
    always_ff @(posedge clk)
    begin
        if (cmd.final_load)
        begin
            for (int i = 0; i < ChainLen; i++)
                dig_reg[i] <= chain_reg[i];
        end
        else if (out_take)
        begin
            for (int i = 0; i < ChainLen - 1; i++)
                dig_reg[i] <= dig_reg[i + 1];
            dig_reg[ChainLen-1] <= dig_reg[ChainLen-1];
        end
    end

endmodule

FILE: hw/rtl/sha1_message_digest.sv
// sha-1 digest of a byte stream; top level with controller and datapath
// one byte beat per cycle while a block fills; a full block then holds the input through
// its 80 rounds on one shared round unit plus the chaining add
// end of message: pad bytes, 8 length bytes, one or two compressions,
// then the digest loads into the output register and drains as 5 word beats, h0 first
// new input is taken while the digest drains; a second end waits until it is gone
// asynchronous active-low reset: chain words to the initial values, counts cleared, output empty
module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [0:0]  s_tuser,   // byte_valid
    input  logic        s_tlast,   // msg_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic        m_tlast    // word_last
);

    cmd_t    cmd;
    status_t st;

    sha1md_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .byte_valid (s_tuser[0]),
        .msg_end    (s_tlast),
        .in_ready   (s_tready),
        .st         (st),
        .cmd        (cmd)
    );

    sha1md_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (s_tdata),
        .cmd         (cmd),
        .st          (st),
        .digest_word (m_tdata),
        .word_last   (m_tlast),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

    // no input beat while the round unit runs
    a_no_accept_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && cmd.round_en))
        else $error("input taken during rounds");

    // compression always starts on a full block
    a_round_on_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round_first |-> (st.fill == '0))
        else $error("rounds started on a partial block");

    // digest load never overwrites words still draining
    a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.final_load |-> !st.out_busy)
        else $error("digest loaded over pending words");

    // a loaded digest is offered on the next cycle
    a_load_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.final_load |=> m_tvalid)
        else $error("digest not offered after load");

endmodule

FILE: tb/tb_sha1_message_digest.sv
// self-checking testbench for the sha-1 message digest block: byte beats in, digest words out
`timescale 1ns / 1ps

module tb_sha1_message_digest;
    import sha1md_pkg::*;

    // one expected digest word beat
    typedef struct {
        logic [31:0] word;
        logic        last;
    } digest_beat_t;

    // running sha-1 of the accepted byte stream and the queue of digest words it predicts
    class digest_scoreboard;
        logic [31:0]  chain_h [5];
        logic [31:0]  blk_w [16];
        logic [5:0]   fill_cnt;
        logic [60:0]  msg_len;
        digest_beat_t digest_q [$];
        int           errors;

        function new();
            errors   = 0;
            restart();
            for (int i = 0; i < 16; i++)
            begin
                blk_w[i] = '0;
            end
        endfunction

        function void restart();
            chain_h[0] = 32'h67452301;
            chain_h[1] = 32'hEFCDAB89;
            chain_h[2] = 32'h98BADCFE;
            chain_h[3] = 32'h10325476;
            chain_h[4] = 32'hC3D2E1F0;
            fill_cnt   = '0;
            msg_len    = '0;
        endfunction

        function logic [31:0] rol(input logic [31:0] x, input int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        // 80 rounds over the current block, then the chaining add
        function void hash_block();
            logic [31:0] w [80];
            logic [31:0] a, b, c, d, e, f, k, t;
            for (int i = 0; i < 16; i++)
            begin
                w[i] = blk_w[i];
            end
            for (int i = 16; i < 80; i++)
            begin
                w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
            end
            a = chain_h[0];
            b = chain_h[1];
            c = chain_h[2];
            d = chain_h[3];
            e = chain_h[4];
            for (int i = 0; i < 80; i++)
            begin
                if (i < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A827999;
                end
                else if (i < 40)
                begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end
                else if (i < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
                t = rol(a, 5) + f + e + k + w[i];
                e = d;
                d = c;
                c = rol(b, 30);
                b = a;
                a = t;
            end
            chain_h[0] += a;
            chain_h[1] += b;
            chain_h[2] += c;
            chain_h[3] += d;
            chain_h[4] += e;
        endfunction

        // big-endian byte lane placement, compress on a full block
        function void push_byte(input logic [7:0] x);
            int lane;
            lane = 3 - int'(fill_cnt[1:0]);
            blk_w[fill_cnt[5:2]][lane*8 +: 8] = x;
            fill_cnt = fill_cnt + 6'd1;
            if (fill_cnt == 6'd0)
            begin
                hash_block();
            end
        endfunction

        // accepted input beat: absorb the byte, on end pad and queue the digest
        function void take_beat(input logic [7:0] d, input logic v, input logic e);
            logic [63:0] bit_len;
            digest_beat_t beat;
            if (v)
            begin
                push_byte(d);
                msg_len = msg_len + 61'd1;
            end
            if (!e)
            begin
                return;
            end
            bit_len = {msg_len, 3'b000};
            push_byte(8'h80);
            while (fill_cnt != 6'd56)
            begin
                push_byte(8'h00);
            end
            blk_w[14] = bit_len[63:32];
            blk_w[15] = bit_len[31:0];
            hash_block();
            for (int i = 0; i < 5; i++)
            begin
                beat.word = chain_h[i];
                beat.last = (i == 4);
                digest_q = {digest_q, beat};
            end
            restart();
        endfunction

        task report(input string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        // accepted output beat against the oldest expected word
        task check_word(input logic [31:0] w, input logic l);
            digest_beat_t exp_beat;
            if (digest_q.size() == 0)
            begin
                report($sformatf("unexpected digest word %h last %b", w, l));
                return;
            end
            exp_beat = digest_q.pop_front();
            if (w !== exp_beat.word)
            begin
                report($sformatf("digest word %h, expected %h", w, exp_beat.word));
            end
            if (l !== exp_beat.last)
            begin
                report($sformatf("word last %b, expected %b", l, exp_beat.last));
            end
        endtask

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // data_byte
    logic [0:0]  s_tuser = 1'b0;    // byte_valid
    logic        s_tlast = 1'b0;    // msg_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // digest_word
    logic        m_tlast;           // word_last

    digest_scoreboard sb = new();

    bit calm = 1'b0;       // no idling on either side
    bit hold_req = 1'b0;   // receiver holds off for a long stretch
    int n_items = 0;
    int n_msgs = 0;

    sha1_message_digest u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // watch both sides for accepted beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                sb.take_beat(s_tdata, s_tuser[0], s_tlast);
        end
    end

    // receiver: random ready pattern, long hold-off on request
    initial
    begin
        int g;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (800) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (calm)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                g = rand_gap();
                if (g > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
        end
    end

    // one input beat, after a random gap
    task automatic send_item(input logic [7:0] d, input logic v, input logic e);
        int g;
        g = calm ? 0 : rand_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= v;
        s_tlast  <= e;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // random message with occasional no-op beats: end rides on the last byte or comes as a beat of its own
    task automatic send_message(input int len);
        bit end_on_byte;
        end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
            n_items++;
        end
        if (!end_on_byte)
        begin
            send_item(8'($urandom), 1'b0, 1'b1);
            n_items++;
        end
        n_msgs++;
    endtask

    // stop offering, then wait until every predicted word has come out
    task automatic wait_digests();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // short messages, or one on the padding and block boundaries
    function automatic int pick_len(input bit on_edge);
        int edges [6] = '{55, 56, 57, 63, 64, 65};
        if (on_edge)
            return edges[$urandom_range(0, 5)];
        return $urandom_range(0, 8);
    endfunction

    // stimulus
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no-op beats, empty message, extreme bytes, "abc", byte then a separate end beat
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h5A, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        wait_digests();

        // back-pressure: receiver stalls while short messages keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 4; i++)
            send_message($urandom_range(1, 4));
        wait_digests();

        // random messages
        n_items = 0;
        n_msgs  = 0;
        while (n_msgs < 10 || n_items < 80)
        begin
            calm = (n_msgs >= 4 && n_msgs < 7);
            send_message(pick_len(n_msgs == 5));
            if (n_msgs == 9)
                wait_digests();
        end
        calm = 1'b0;

        // drain, then let any stray beat show up
        wait_digests();
        repeat (400) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sha1_message_digest.f
hw/rtl/sha1md_pkg.sv
hw/rtl/sha1md_ctrl.sv
hw/rtl/sha1md_dp.sv
hw/rtl/sha1_message_digest.sv
tb/tb_sha1_message_digest.sv
